@@ sv/flat_shade_intensity_top_assert.svh @@
// Assertion macros for the flat shading intensity pipeline.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef FLAT_SHADE_INTENSITY_TOP_ASSERT_SVH
`define FLAT_SHADE_INTENSITY_TOP_ASSERT_SVH

// Checks that a condition holds at every clock edge outside reset.
`define FSI_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Checks that a trigger is followed in the next cycle by a consequence.
`define FSI_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/fsi_pkg.sv @@
// Package for the flat shading intensity pipeline.
// Holds shading constants, field widths and register indexes; no dependencies.
package fsi_pkg;

  localparam logic [7:0] AMBIENT = 8'd30;
  localparam logic [7:0] KMAX    = 8'd225;

  localparam int NUM_STAGES = 17;
  localparam int SRCH_BITS  = 8;
  localparam int CC_W       = 68;
  localparam int RES_W      = 120;

  typedef enum logic [1:0] {
    REG_LIGHT_X = 2'd0,
    REG_LIGHT_Y = 2'd1,
    REG_LIGHT_Z = 2'd2,
    REG_NONE    = 2'd3
  } reg_idx_e;

endpackage

@@ sv/flat_shade_intensity_top.sv @@
// Flat Lambert shading: face normal, light dot product and exact diffuse level.
// Depends on fsi_pkg and on flat_shade_intensity_top_assert.svh.
//
// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_stall_o    v0_x_i .. v2_z_i, 16 bit signed
// out       output     out_valid_o / out_stall_i  intensity_o, 8 bit unsigned
// config    input      APB psel/penable/pwrite    light_x/y/z at 0x0, 0x4, 0x8
//
// One transaction may enter every cycle unless a stalled output holds the pipeline.
// Eight of the pipeline stages form the bit-serial diffuse search.
// Reset clears all valid bits and loads the light with (0, 0, 16384).
// A stalled output freezes the whole pipeline, and in_stall_o rises at once.
`include "flat_shade_intensity_top_assert.svh"

module flat_shade_intensity_top
  import fsi_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] v0_x_i,
  input  logic signed [15:0] v0_y_i,
  input  logic signed [15:0] v0_z_i,
  input  logic signed [15:0] v1_x_i,
  input  logic signed [15:0] v1_y_i,
  input  logic signed [15:0] v1_z_i,
  input  logic signed [15:0] v2_x_i,
  input  logic signed [15:0] v2_y_i,
  input  logic signed [15:0] v2_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         intensity_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic signed [15:0] light_x_q, light_y_q, light_z_q;
  reg_idx_e           reg_idx;
  logic               wr_en;

  logic [NUM_STAGES-1:0] valid_q;
  logic                  adv;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_x_q <= 16'sd0;
      light_y_q <= 16'sd0;
      light_z_q <= 16'sd16384;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_LIGHT_X: light_x_q <= pwdata[15:0];
        REG_LIGHT_Y: light_y_q <= pwdata[15:0];
        REG_LIGHT_Z: light_z_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LIGHT_X: prdata = {16'd0, light_x_q};
      REG_LIGHT_Y: prdata = {16'd0, light_y_q};
      REG_LIGHT_Z: prdata = {16'd0, light_z_q};
      default:     prdata = 32'd0;
    endcase
  end

  assign adv        = !(valid_q[NUM_STAGES-1] && out_stall_i);
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[NUM_STAGES-2:0], in_valid_i};
    end
  end

  // Edge vectors.
  logic signed [16:0] ax_q, ay_q, az_q, bx_q, by_q, bz_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ax_q <= 17'(v1_x_i) - 17'(v0_x_i);
      ay_q <= 17'(v1_y_i) - 17'(v0_y_i);
      az_q <= 17'(v1_z_i) - 17'(v0_z_i);
      bx_q <= 17'(v2_x_i) - 17'(v0_x_i);
      by_q <= 17'(v2_y_i) - 17'(v0_y_i);
      bz_q <= 17'(v2_z_i) - 17'(v0_z_i);
    end
  end

  // Cross product partial products.
  logic signed [33:0] m0_q, m1_q, m2_q, m3_q, m4_q, m5_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      m0_q <= ay_q * bz_q;
      m1_q <= az_q * by_q;
      m2_q <= az_q * bx_q;
      m3_q <= ax_q * bz_q;
      m4_q <= ax_q * by_q;
      m5_q <= ay_q * bx_q;
    end
  end

  logic signed [34:0] cx_q, cy_q, cz_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      cx_q <= 35'(m0_q) - 35'(m1_q);
      cy_q <= 35'(m2_q) - 35'(m3_q);
      cz_q <= 35'(m4_q) - 35'(m5_q);
    end
  end

  logic [33:0] cx_mag, cy_mag, cz_mag;
  assign cx_mag = cx_q[34] ? 34'(-cx_q) : cx_q[33:0];
  assign cy_mag = cy_q[34] ? 34'(-cy_q) : cy_q[33:0];
  assign cz_mag = cz_q[34] ? 34'(-cz_q) : cz_q[33:0];

  logic signed [50:0] pdx_q, pdy_q, pdz_q;
  logic [67:0]        sqx_q, sqy_q, sqz_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pdx_q <= cx_q * light_x_q;
      pdy_q <= cy_q * light_y_q;
      pdz_q <= cz_q * light_z_q;
      sqx_q <= cx_mag * cx_mag;
      sqy_q <= cy_mag * cy_mag;
      sqz_q <= cz_mag * cz_mag;
    end
  end

  logic signed [51:0] dot_d;
  logic signed [51:0] dot_q;
  logic [CC_W-1:0]    cc5_q;
  logic               pos5_q;
  assign dot_d = 52'(pdx_q) + 52'(pdy_q) + 52'(pdz_q);
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dot_q  <= dot_d;
      cc5_q  <= sqx_q + sqy_q + sqz_q;
      pos5_q <= !dot_d[51] && (dot_d != 52'sd0);
    end
  end

  // Scaled dot product, zeroed when the face turns away.
  logic [59:0]     e_q;
  logic [CC_W-1:0] cc6_q;
  logic            pos6_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      e_q    <= pos5_q ? ({9'd0, dot_q[50:0]} << 8) - {9'd0, dot_q[50:0]} : 60'd0;
      cc6_q  <= cc5_q;
      pos6_q <= pos5_q;
    end
  end

  logic [59:0]     hh_q, hl_q, ll_q;
  logic [CC_W-1:0] cc7_q;
  logic            pos7_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      hh_q   <= e_q[59:30] * e_q[59:30];
      hl_q   <= e_q[59:30] * e_q[29:0];
      ll_q   <= e_q[29:0] * e_q[29:0];
      cc7_q  <= cc6_q;
      pos7_q <= pos6_q;
    end
  end

  // Search stage inputs; entry 0 holds the squared scaled dot product.
  logic [RES_W-1:0] res_q [0:SRCH_BITS];
  logic [7:0]       k_q   [0:SRCH_BITS];
  logic [CC_W-1:0]  cc_q  [0:SRCH_BITS];
  logic             pos_q [0:SRCH_BITS];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q[0] <= ({hh_q, 60'd0}) + ({29'd0, hl_q, 31'd0}) + ({60'd0, ll_q});
      k_q[0]   <= 8'd0;
      cc_q[0]  <= cc7_q;
      pos_q[0] <= pos7_q;
    end
  end

  for (genvar j = 0; j < SRCH_BITS; j++) begin : g_srch
    localparam int B = SRCH_BITS - 1 - j;
    logic [16:0]      step_m;
    logic [84:0]      prod;
    logic [RES_W-1:0] delta;
    logic             fit;

    assign step_m = (17'(k_q[j]) << (B + 1)) + (17'd1 << (2 * B));
    assign prod   = cc_q[j] * step_m;
    assign delta  = {7'd0, prod, 28'd0};
    assign fit    = delta <= res_q[j];

    always_ff @(posedge clk_i) begin
      if (adv) begin
        res_q[j+1] <= fit ? res_q[j] - delta : res_q[j];
        k_q[j+1]   <= fit ? (k_q[j] | (8'd1 << B)) : k_q[j];
        cc_q[j+1]  <= cc_q[j];
        pos_q[j+1] <= pos_q[j];
      end
    end
  end

  logic [7:0] k_cap;
  logic [7:0] intensity_q;
  assign k_cap = (k_q[SRCH_BITS] > KMAX) ? KMAX : k_q[SRCH_BITS];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      intensity_q <= pos_q[SRCH_BITS] ? AMBIENT + k_cap : AMBIENT;
    end
  end

  assign out_valid_o = valid_q[NUM_STAGES-1];
  assign intensity_o = intensity_q;

  `FSI_ASSERT_ALWAYS(a_int_floor, !out_valid_o || (intensity_o >= AMBIENT), "intensity below ambient")
  `FSI_ASSERT_NEXT(a_accept_enters, in_valid_i && !in_stall_o, valid_q[0], "accepted transaction lost")
  `FSI_ASSERT_NEXT(a_freeze, !adv, $stable(valid_q) && $stable(intensity_o), "pipeline moved while stalled")

endmodule
